[sv/yse_pkg.sv]
// Package for the YAML double-quoted string escaper.
// Holds the request, run and result types, character constants and the hex digit helper.
// No dependencies.
`default_nettype none

package yse_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 4;

    // Input request: one character, or the end-of-string command.
    typedef struct packed {
        logic            command;
        logic [CP_W-1:0] code_point;
    } t_in_item;

    // One output code point of the quoted text.
    typedef struct packed {
        logic [CP_W-1:0] out_char;
        logic            last_of_run;
        logic            string_closed;
    } t_out_item;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [2:0] {
        CLS_PLAIN,
        CLS_END,
        CLS_PAIR,
        CLS_HEX2,
        CLS_HEX8
    } t_cls;

    // Decoded request waiting to be expanded into output characters.
    typedef struct packed {
        logic             quote;
        t_cls             cls;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
    } t_run;

    localparam logic [CP_W-1:0] CH_TAB     = 21'h09;
    localparam logic [CP_W-1:0] CH_LF      = 21'h0A;
    localparam logic [CP_W-1:0] CH_SPACE   = 21'h20;
    localparam logic [CP_W-1:0] CH_QUOTE   = 21'h22;
    localparam logic [CP_W-1:0] CH_ZERO    = 21'h30;
    localparam logic [CP_W-1:0] CH_UPPER_U = 21'h55;
    localparam logic [CP_W-1:0] CH_BSLASH  = 21'h5C;
    localparam logic [CP_W-1:0] CH_LOWER_A = 21'h61;
    localparam logic [CP_W-1:0] CH_LOWER_N = 21'h6E;
    localparam logic [CP_W-1:0] CH_LOWER_T = 21'h74;
    localparam logic [CP_W-1:0] CH_LOWER_X = 21'h78;
    localparam logic [CP_W-1:0] CH_DEL     = 21'h7F;
    localparam logic [CP_W-1:0] CH_C1_LAST = 21'h9F;
    localparam logic [CP_W-1:0] CH_LSEP    = 21'h2028;
    localparam logic [CP_W-1:0] CH_PSEP    = 21'h2029;
    localparam logic [CP_W-1:0] CH_NONCHAR = 21'hFFFE;
    localparam logic [CP_W-1:0] CH_MAX     = 21'h1FFFFF;

    // Lowercase hex character for one nibble.
    function automatic logic [CP_W-1:0] hex_char(input logic [3:0] nib);
        logic [CP_W-1:0] wide;
        wide = {{(CP_W-4){1'b0}}, nib};
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + wide;
        end else begin
            hex_char = CH_LOWER_A + wide - 21'd10;
        end
    endfunction

endpackage

`default_nettype wire

[sv/yse_classify.sv]
// Input stage of the escaper: takes requests, tracks the open-quote flag and
// registers a decoded run descriptor. Depends on yse_pkg.
`default_nettype none

module yse_classify (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  yse_pkg::t_in_item i_in_data,
    output logic              o_run_valid,
    output yse_pkg::t_run     o_run,
    input  wire               i_run_take
);

    logic          r_quote_opened;
    logic          r_run_valid;
    yse_pkg::t_run r_run;
    yse_pkg::t_run n_run;
    logic          w_accept;
    logic [3:0]    w_base;

    assign o_in_ready  = !r_run_valid || i_run_take;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_run_valid = r_run_valid;
    assign o_run       = r_run;

    always_comb begin
        n_run.quote = !r_quote_opened;
        n_run.cp    = i_in_data.code_point;
        n_run.cls   = yse_pkg::CLS_PLAIN;
        w_base      = 4'd1;
        if (i_in_data.command == yse_pkg::CMD_END) begin
            n_run.cls = yse_pkg::CLS_END;
            w_base    = 4'd1;
        end else if (i_in_data.code_point == yse_pkg::CH_BSLASH
                     || i_in_data.code_point == yse_pkg::CH_QUOTE) begin
            n_run.cls = yse_pkg::CLS_PAIR;
            w_base    = 4'd2;
        end else if (i_in_data.code_point == yse_pkg::CH_LF) begin
            n_run.cls = yse_pkg::CLS_PAIR;
            n_run.cp  = yse_pkg::CH_LOWER_N;
            w_base    = 4'd2;
        end else if (i_in_data.code_point == yse_pkg::CH_TAB) begin
            n_run.cls = yse_pkg::CLS_PAIR;
            n_run.cp  = yse_pkg::CH_LOWER_T;
            w_base    = 4'd2;
        end else if (i_in_data.code_point < yse_pkg::CH_SPACE
                     || i_in_data.code_point inside
                        {[yse_pkg::CH_DEL:yse_pkg::CH_C1_LAST]}) begin
            n_run.cls = yse_pkg::CLS_HEX2;
            w_base    = 4'd4;
        end else if (i_in_data.code_point inside
                        {yse_pkg::CH_LSEP, yse_pkg::CH_PSEP,
                         [yse_pkg::CH_NONCHAR:yse_pkg::CH_MAX]}) begin
            n_run.cls = yse_pkg::CLS_HEX8;
            w_base    = 4'd10;
        end
        // The opening quote, when due, adds one character in front.
        n_run.len = w_base + {3'd0, !r_quote_opened};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_opened <= 1'b0;
            r_run_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_quote_opened <= (i_in_data.command != yse_pkg::CMD_END);
                r_run_valid    <= 1'b1;
            end else if (i_run_take) begin
                r_run_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_run <= n_run;
        end
    end

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.command == yse_pkg::CMD_END |=> !r_quote_opened)
        else $error("quote flag still set after end of string");

    a_quote_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid && r_run.quote && r_run.cls != yse_pkg::CLS_END |-> r_quote_opened)
        else $error("opening quote issued but flag not set");

endmodule

`default_nettype wire

[sv/yse_emit.sv]
// Output stage of the escaper: walks a run descriptor one character per cycle
// into the result register while the output is ready. Depends on yse_pkg.
`default_nettype none

module yse_emit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_run_valid,
    input  yse_pkg::t_run      i_run,
    output logic               o_run_take,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output yse_pkg::t_out_item o_out_data
);

    logic [yse_pkg::LEN_W-1:0] r_idx;
    logic [yse_pkg::LEN_W-1:0] n_idx;
    logic                      r_out_valid;
    yse_pkg::t_out_item        r_out_data;
    yse_pkg::t_out_item        n_out_data;
    logic                      w_load;
    logic                      w_last;
    logic [yse_pkg::LEN_W-1:0] w_pos;
    logic [2:0]                w_digit;
    logic [2:0]                w_sel;
    logic [31:0]               w_cp32;
    logic [3:0]                w_nib;

    assign w_load      = i_run_valid && (!r_out_valid || i_out_ready);
    assign w_last      = (r_idx == i_run.len - 4'd1);
    assign o_run_take  = w_load && w_last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign n_idx       = w_last ? '0 : r_idx + 4'd1;

    // Position within the run once the opening quote is taken off.
    assign w_pos   = i_run.quote ? r_idx - 4'd1 : r_idx;
    assign w_digit = w_pos[2:0] - 3'd2;
    assign w_sel   = (i_run.cls == yse_pkg::CLS_HEX8) ? 3'd7 - w_digit : 3'd1 - w_digit;
    assign w_cp32  = {11'd0, i_run.cp};
    assign w_nib   = w_cp32[{w_sel, 2'b00} +: 4];

    always_comb begin
        n_out_data.last_of_run   = w_last;
        n_out_data.string_closed = 1'b0;
        n_out_data.out_char      = i_run.cp;
        if (i_run.quote && r_idx == '0) begin
            n_out_data.out_char = yse_pkg::CH_QUOTE;
        end else begin
            case (i_run.cls)
                yse_pkg::CLS_PLAIN: begin
                    n_out_data.out_char = i_run.cp;
                end
                yse_pkg::CLS_END: begin
                    n_out_data.out_char      = yse_pkg::CH_QUOTE;
                    n_out_data.string_closed = 1'b1;
                end
                yse_pkg::CLS_PAIR: begin
                    n_out_data.out_char = (w_pos == '0) ? yse_pkg::CH_BSLASH : i_run.cp;
                end
                yse_pkg::CLS_HEX2, yse_pkg::CLS_HEX8: begin
                    if (w_pos == '0) begin
                        n_out_data.out_char = yse_pkg::CH_BSLASH;
                    end else if (w_pos == 4'd1) begin
                        n_out_data.out_char = (i_run.cls == yse_pkg::CLS_HEX8)
                                              ? yse_pkg::CH_UPPER_U : yse_pkg::CH_LOWER_X;
                    end else begin
                        n_out_data.out_char = yse_pkg::hex_char(w_nib);
                    end
                end
                default: begin
                    n_out_data.out_char = i_run.cp;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.string_closed |-> r_out_data.last_of_run
            && r_out_data.out_char == yse_pkg::CH_QUOTE)
        else $error("closing quote not at the end of its run");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run_valid |-> r_idx < i_run.len)
        else $error("character index beyond run length");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_run_valid |-> r_idx == '0)
        else $error("character index left over between runs");

endmodule

`default_nettype wire

[sv/yaml_string_escaper_unit.sv]
// YAML double-quoted string escaper, top level.
// Instantiates yse_classify and yse_emit; depends on yse_pkg.
//
// Each request is one code point or an end-of-string command and produces one
// to eleven output code points: the opening quote ahead of a string's first
// character, the character itself or its escape sequence, and the closing
// quote on the end command. Requests are decoded into a one-entry descriptor
// register, and the emitter writes one output character per cycle, when the
// output is ready, into the result register, so that single output port sets
// throughput. A plain character gives one output character, an escape two,
// four or ten, plus one for an opening quote, and the input is held off while
// they drain. A new request is taken in the same cycle as the last character
// of the previous one, so plain text streams one per cycle when the output is
// ready. Each request passes through the descriptor and result registers.
`default_nettype none

module yaml_string_escaper_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  yse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output yse_pkg::t_out_item o_out_data
);

    logic          w_run_valid;
    logic          w_run_take;
    yse_pkg::t_run w_run;

    yse_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_run_valid (w_run_valid),
        .o_run       (w_run),
        .i_run_take  (w_run_take)
    );

    yse_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (w_run_valid),
        .i_run       (w_run),
        .o_run_take  (w_run_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
